FILE: src/bsc_pkg.sv
package bsc_pkg;

	// Item commands
	localparam logic [1:0] CMD_START  = 2'd0;
	localparam logic [1:0] CMD_DATA   = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;

	// Register indexes on the configuration port
	localparam int unsigned         CFG_IDX_W         = 2;
	localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_DISABLE = 2'd1;

	// Trailer beat positions
	localparam logic [2:0] TRL_SEED_HI = 3'd0;
	localparam logic [2:0] TRL_SEED_MD = 3'd1;
	localparam logic [2:0] TRL_SEED_LO = 3'd2;
	localparam logic [2:0] TRL_SUM_HI  = 3'd3;
	localparam logic [2:0] TRL_SUM_LO  = 3'd4;

	// Generator constants
	localparam logic [23:0] GEN_MUL = 24'd153;
	localparam logic [23:0] GEN_INC = 24'd97;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  data_byte;
		logic [23:0] seed;
		logic [15:0] expected_check;
	} item_t;

	typedef struct packed {
		logic decode_mode;
		logic check_disable;
	} cfg_t;

	typedef struct packed {
		logic       take;
		logic [2:0] trl_cnt;
	} eng_sts_t;

	// Next generator value, modulo 2^24
	function automatic logic [23:0] gen_next(input logic [23:0] g);
		gen_next = g * GEN_MUL + GEN_INC;
	endfunction

	// Running checksum step, modulo 2^16
	function automatic logic [15:0] sum_next(input logic [15:0] s, input logic [7:0] b);
		sum_next = {s[14:0], 1'b0} + s + {8'd0, b};
	endfunction

endpackage

FILE: src/bsc_if.sv
// Input item channel
interface bsc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [7:0]  data_byte;
	logic [23:0] seed;
	logic [15:0] expected_check;

	modport source (output valid, command, data_byte, seed, expected_check, input ready);
	modport sink   (input valid, command, data_byte, seed, expected_check, output ready);
endinterface

// Result channel
interface bsc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;
	logic       check_error;
	logic       is_trailer;

	modport source (output valid, out_byte, last, check_error, is_trailer, input ready);
	modport sink   (input valid, out_byte, last, check_error, is_trailer, output ready);
endinterface

// Register write channel
interface bsc_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic       data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/bsc_input_stage.sv
module bsc_input_stage
	import bsc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	bsc_in_if.sink    item,
	input  logic      take,
	output logic      valid_s1,
	output item_t     item_s1
);

	logic accept;

	// Free when empty or when the held beat leaves this cycle
	assign item.ready = !valid_s1 || take;
	assign accept     = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.command        <= item.command;
			item_s1.data_byte      <= item.data_byte;
			item_s1.seed           <= item.seed;
			item_s1.expected_check <= item.expected_check;
		end
	end

endmodule

FILE: src/bsc_engine.sv
module bsc_engine
	import bsc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      valid_s1,
	input  item_t     item_s1,
	input  cfg_t      cfg,
	bsc_out_if.source result,
	output eng_sts_t  sts
);

	logic [23:0] gen_q;
	logic [23:0] start_q;
	logic [15:0] sum_q;
	logic [2:0]  trl_cnt_q;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        last_q;
	logic        err_q;
	logic        trl_q;

	logic        out_free;
	logic        take;
	logic        emit;
	logic        load_seed;
	logic        step_data;
	logic        trl_step;
	logic [23:0] gen_nx;
	logic [7:0]  key;
	logic [7:0]  plain;
	logic [7:0]  res_byte;
	logic        res_last;
	logic        res_err;
	logic        res_trl;

	assign out_free = !out_valid_q || result.ready;

	// Generator step and byte transform
	assign gen_nx = gen_next(gen_q);
	assign key    = gen_nx[7:0] + 8'd1;
	assign plain  = cfg.decode_mode ? (item_s1.data_byte - key) : item_s1.data_byte;

	// Per-command decisions for the held beat
	always_comb begin
		take      = 1'b0;
		emit      = 1'b0;
		load_seed = 1'b0;
		step_data = 1'b0;
		trl_step  = 1'b0;
		res_byte  = 8'd0;
		res_last  = 1'b0;
		res_err   = 1'b0;
		res_trl   = 1'b0;
		if (valid_s1) begin
			unique case (item_s1.command)
				CMD_START: begin
					take      = 1'b1;
					load_seed = 1'b1;
				end
				CMD_DATA: begin
					take      = out_free;
					emit      = 1'b1;
					step_data = out_free;
					res_byte  = cfg.decode_mode ? plain : (item_s1.data_byte + key);
				end
				CMD_FINISH: begin
					emit = 1'b1;
					if (cfg.decode_mode) begin
						take     = out_free;
						res_last = 1'b1;
						res_err  = (item_s1.expected_check != sum_q) && !cfg.check_disable;
					end else begin
						trl_step = out_free;
						take     = out_free && (trl_cnt_q == TRL_SUM_LO);
						res_trl  = 1'b1;
						res_last = (trl_cnt_q == TRL_SUM_LO);
						unique case (trl_cnt_q)
							TRL_SEED_HI: res_byte = start_q[23:16];
							TRL_SEED_MD: res_byte = start_q[15:8];
							TRL_SEED_LO: res_byte = start_q[7:0];
							TRL_SUM_HI:  res_byte = sum_q[15:8];
							default:     res_byte = sum_q[7:0];
						endcase
					end
				end
				// unused code: dropped without effect
				default: take = 1'b1;
			endcase
		end
	end

	// Block state and trailer position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q     <= 24'd0;
			start_q   <= 24'd0;
			sum_q     <= 16'd0;
			trl_cnt_q <= TRL_SEED_HI;
		end else begin
			if (load_seed) begin
				gen_q   <= item_s1.seed;
				start_q <= item_s1.seed;
				sum_q   <= 16'd0;
			end else if (step_data) begin
				gen_q <= gen_nx;
				sum_q <= sum_next(sum_q, plain);
			end
			if (trl_step) begin
				trl_cnt_q <= (trl_cnt_q == TRL_SUM_LO) ? TRL_SEED_HI : trl_cnt_q + 3'd1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && out_free) begin
			out_byte_q <= res_byte;
			last_q     <= res_last;
			err_q      <= res_err;
			trl_q      <= res_trl;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.out_byte    = out_byte_q;
	assign result.last        = last_q;
	assign result.check_error = err_q;
	assign result.is_trailer  = trl_q;

	assign sts.take    = take;
	assign sts.trl_cnt = trl_cnt_q;

endmodule

FILE: src/block_scrambler_with_checksum_unit.sv
// Channel   Role   Beat contents
// item      sink   command, data_byte, seed, expected_check
// result    source out_byte, last, check_error, is_trailer
// cfg       sink   index, data (decode_mode, check_disable)
//
// One item per cycle while the result is not stalled and no encode finish is held: a data
// beat is captured in the input register, then its result beat is registered in the result
// register and offered from there; a start beat only loads state. The generator multiply-add is the longest path.
// An encode finish holds the input register for five trailer beats, one per position.
// Reset clears generator, seed copy, checksum, trailer position, settings and valid flags.
// A stalled result stalls the input stage only once the result register is full.
module block_scrambler_with_checksum_unit
	import bsc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	bsc_in_if.sink    item,
	bsc_out_if.source result,
	bsc_cfg_if.sink   cfg
);

	cfg_t     cfg_q;
	logic     valid_s1;
	item_t    item_s1;
	eng_sts_t sts;

	// Register writes always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			if (cfg.index == REG_DECODE_MODE) begin
				cfg_q.decode_mode <= cfg.data;
			end else if (cfg.index == REG_CHECK_DISABLE) begin
				cfg_q.check_disable <= cfg.data;
			end
		end
	end

	bsc_input_stage u_input (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.take     (sts.take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	bsc_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.cfg      (cfg_q),
		.result   (result),
		.sts      (sts)
	);

	// Trailer runs only while an encode finish is held
	a_trl_held: assert property (@(posedge clk) disable iff (!arst_n)
		sts.trl_cnt != TRL_SEED_HI |-> valid_s1 && item_s1.command == CMD_FINISH)
		else $error("trailer position set without a held finish");

	// An encode finish leaves only after its last trailer beat
	a_trl_done: assert property (@(posedge clk) disable iff (!arst_n)
		sts.take && valid_s1 && item_s1.command == CMD_FINISH && !cfg_q.decode_mode
		|-> sts.trl_cnt == TRL_SUM_LO)
		else $error("encode finish released early");

	// After the last trailer beat the position returns to the start
	a_trl_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		sts.take && sts.trl_cnt == TRL_SUM_LO |=> sts.trl_cnt == TRL_SEED_HI)
		else $error("trailer position did not wrap");

	// A mismatch flag only rides on a closing, non-trailer beat
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.check_error |-> result.last && !result.is_trailer)
		else $error("check_error on a wrong beat");

endmodule
